// ----- hw/rtl/dp_link_training_sequencer_top_macros.svh -----
// ----------------------------------------------------------------------------
// dp_link_training_sequencer_top_macros.svh
// Assertion macros shared by the link training checker.
// ----------------------------------------------------------------------------
`ifndef DP_LINK_TRAINING_SEQUENCER_TOP_MACROS_SVH
`define DP_LINK_TRAINING_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DPLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dplt assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define DPLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dplt assertion failed");

`endif

// ----- hw/rtl/dplt_pkg.sv -----
// ----------------------------------------------------------------------------
// dplt_pkg
// Types and codes of the DisplayPort link training sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dplt_pkg;

  localparam int LANES = 4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_CR   = 3'b010,
    PH_EQ   = 3'b100
  } dplt_phase_t;

  localparam logic [2:0] ACT_IGNORED     = 3'd0;
  localparam logic [2:0] ACT_SET_PATTERN = 3'd1;
  localparam logic [2:0] ACT_SET_LEVELS  = 3'd2;
  localparam logic [2:0] ACT_DONE        = 3'd3;
  localparam logic [2:0] ACT_FAILED      = 3'd4;

  localparam logic [2:0] FAIL_NONE      = 3'd0;
  localparam logic [2:0] FAIL_READ      = 3'd1;
  localparam logic [2:0] FAIL_MAX_SWING = 3'd2;
  localparam logic [2:0] FAIL_CR_RETRY  = 3'd3;
  localparam logic [2:0] FAIL_EQ_RETRY  = 3'd4;

  localparam logic [1:0] PAT_OFF = 2'd0;
  localparam logic [1:0] PAT_1   = 2'd1;
  localparam logic [1:0] PAT_2   = 2'd2;
  localparam logic [1:0] PAT_3   = 2'd3;

  localparam logic [1:0] LEVEL_MAX = 2'd3;

  localparam logic CFG_NUM_LANES = 1'b0;
  localparam logic CFG_PATTERN3  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic             status_read_ok;
    logic [LANES-1:0] lane_cr_done;
    logic [LANES-1:0] lane_eq_done;
    logic             lanes_aligned;
    logic [7:0]       req_voltage;
    logic [7:0]       req_preemph;
  } dplt_item_t;

  typedef struct packed {
    dplt_phase_t phase;
    logic [2:0]  try_count;
    logic [1:0]  prev_voltage;
    logic        prev_voltage_valid;
    logic [1:0]  voltage_level;
    logic [1:0]  preemph_level;
    logic        swing_at_max;
    logic        preemph_at_max;
  } dplt_state_t;

  localparam dplt_state_t STATE_RESET = '{phase: PH_IDLE, default: '0};

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] pattern;
    logic [1:0] drive_voltage;
    logic [1:0] drive_preemph;
    logic       swing_max_flag;
    logic       preemph_max_flag;
    logic [2:0] fail_reason;
  } dplt_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dplt_step.sv -----
// ----------------------------------------------------------------------------
// dplt_step
// Decision logic for one item: next training state and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dplt_step #(
  parameter int MAX_LANES             = 4,
  parameter int CR_SAME_VOLTAGE_LIMIT = 5,
  parameter int EQ_RETRY_LIMIT        = 5
) (
  input  dplt_pkg::dplt_state_t  st,
  input  dplt_pkg::dplt_item_t   item,
  input  logic [2:0]             num_lanes,
  input  logic                   pattern3_allowed,
  output dplt_pkg::dplt_state_t  st_next,
  output dplt_pkg::dplt_result_t res
);
  import dplt_pkg::*;

  localparam logic [2:0] MaxLanes   = 3'(MAX_LANES);
  localparam logic [2:0] CrSameLim  = 3'(CR_SAME_VOLTAGE_LIMIT);
  localparam logic [2:0] EqRetryLim = 3'(EQ_RETRY_LIMIT);

  logic [2:0]       n_eff;
  logic [LANES-1:0] mask;
  logic [1:0]       vmax;
  logic [1:0]       pmax;
  logic [1:0]       eq_pat;
  logic             cr_all;
  logic             eq_all;
  logic [2:0]       try_inc;
  logic             show_levels;

  always_comb begin
    n_eff = num_lanes;
    if (n_eff == 3'd0) begin
      n_eff = 3'd1;
    end
    if (n_eff > MaxLanes) begin
      n_eff = MaxLanes;
    end
    for (int k = 0; k < LANES; k++) begin
      mask[k] = 3'(k) < n_eff;
    end
  end

  always_comb begin
    vmax = '0;
    pmax = '0;
    for (int k = 0; k < LANES; k++) begin
      if (mask[k] && item.req_voltage[2*k +: 2] > vmax) begin
        vmax = item.req_voltage[2*k +: 2];
      end
      if (mask[k] && item.req_preemph[2*k +: 2] > pmax) begin
        pmax = item.req_preemph[2*k +: 2];
      end
    end
  end

  assign eq_pat  = pattern3_allowed ? PAT_3 : PAT_2;
  assign cr_all  = (item.lane_cr_done & mask) == mask;
  assign eq_all  = (item.lane_eq_done & mask) == mask;
  assign try_inc = st.try_count + 3'd1;

  always_comb begin
    st_next     = st;
    res         = '0;
    show_levels = 1'b1;
    if (!item.mode) begin
      st_next       = STATE_RESET;
      st_next.phase = PH_CR;
      res.action    = ACT_SET_PATTERN;
      res.pattern   = PAT_1;
    end else begin
      case (st.phase)
        PH_CR: begin
          if (!item.status_read_ok) begin
            st_next.phase   = PH_IDLE;
            res.action      = ACT_FAILED;
            res.fail_reason = FAIL_READ;
          end else if (cr_all) begin
            st_next.phase     = PH_EQ;
            st_next.try_count = '0;
            res.action        = ACT_SET_PATTERN;
            res.pattern       = eq_pat;
          end else if (st.swing_at_max) begin
            st_next.phase   = PH_IDLE;
            res.action      = ACT_FAILED;
            res.fail_reason = FAIL_MAX_SWING;
          end else if (st.prev_voltage_valid && st.prev_voltage == st.voltage_level
                       && try_inc == CrSameLim) begin
            st_next.try_count = try_inc;
            st_next.phase     = PH_IDLE;
            res.action        = ACT_FAILED;
            res.fail_reason   = FAIL_CR_RETRY;
          end else begin
            if (st.prev_voltage_valid && st.prev_voltage == st.voltage_level) begin
              st_next.try_count = try_inc;
            end else begin
              st_next.try_count = '0;
            end
            st_next.prev_voltage       = st.voltage_level;
            st_next.prev_voltage_valid = 1'b1;
            st_next.voltage_level      = vmax;
            st_next.preemph_level      = pmax;
            st_next.swing_at_max       = vmax >= LEVEL_MAX;
            st_next.preemph_at_max     = pmax >= LEVEL_MAX;
            res.action                 = ACT_SET_LEVELS;
            res.pattern                = PAT_1;
          end
        end
        PH_EQ: begin
          if (!item.status_read_ok) begin
            st_next.phase   = PH_IDLE;
            res.action      = ACT_FAILED;
            res.fail_reason = FAIL_READ;
          end else if (cr_all && eq_all && item.lanes_aligned) begin
            st_next.phase = PH_IDLE;
            res.action    = ACT_DONE;
          end else if (st.try_count > EqRetryLim) begin
            st_next.phase   = PH_IDLE;
            res.action      = ACT_FAILED;
            res.fail_reason = FAIL_EQ_RETRY;
          end else begin
            st_next.voltage_level  = vmax;
            st_next.preemph_level  = pmax;
            st_next.swing_at_max   = vmax >= LEVEL_MAX;
            st_next.preemph_at_max = pmax >= LEVEL_MAX;
            st_next.try_count      = try_inc;
            res.action             = ACT_SET_LEVELS;
            res.pattern            = eq_pat;
          end
        end
        default: begin
          st_next.phase = PH_IDLE;
          show_levels   = 1'b0;
        end
      endcase
    end
    if (show_levels) begin
      res.drive_voltage    = st_next.voltage_level;
      res.drive_preemph    = st_next.preemph_level;
      res.swing_max_flag   = st_next.swing_at_max;
      res.preemph_max_flag = st_next.preemph_at_max;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dp_link_training_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// dp_link_training_sequencer_top
// Source-side DisplayPort link training sequencer.
//
//   Channel   Dir  Handshake                  Carries
//   s_axis    in   s_axis_tvalid/tready       start or sink status report
//   m_axis    out  m_axis_tvalid/tready       one action per item
//   cfg       in   cfg_valid/cfg_ready        num_lanes, pattern3_allowed
//
// One item per cycle sustained while m_axis_tready is high; the input register
// and the result register lie around the decision from input to result.
// rst clears the handshake, the training state and the registers.
// A stalled result holds the input register; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module dp_link_training_sequencer_top #(
  parameter int MAX_LANES             = 4,
  parameter int CR_SAME_VOLTAGE_LIMIT = 5,
  parameter int EQ_RETRY_LIMIT        = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status_read_ok, lane_cr_done[4], lane_eq_done[4], lanes_aligned,
  // req_voltage[8], req_preemph[8], zero fill
  input  logic [31:0] s_axis_tdata,
  // mode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pattern[2], drive_voltage[2], drive_preemph[2], swing_max_flag,
  // preemph_max_flag, fail_reason[3], zero fill
  output logic [15:0] m_axis_tdata,
  // action
  output logic [2:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);
  import dplt_pkg::*;

  logic         in_valid;
  dplt_item_t   in_item;
  logic [2:0]   num_lanes;
  logic         pattern3_allowed;
  dplt_state_t  st;
  dplt_state_t  st_next;
  dplt_result_t res;
  logic         out_valid;
  dplt_result_t out_res;
  logic         advance;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_lanes        <= 3'd1;
      pattern3_allowed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_LANES: num_lanes <= cfg_data;
        CFG_PATTERN3:  pattern3_allowed <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= '{mode:           s_axis_tuser,
                   status_read_ok: s_axis_tdata[0],
                   lane_cr_done:   s_axis_tdata[4:1],
                   lane_eq_done:   s_axis_tdata[8:5],
                   lanes_aligned:  s_axis_tdata[9],
                   req_voltage:    s_axis_tdata[17:10],
                   req_preemph:    s_axis_tdata[25:18]};
    end
  end

  dplt_step #(
    .MAX_LANES             (MAX_LANES),
    .CR_SAME_VOLTAGE_LIMIT (CR_SAME_VOLTAGE_LIMIT),
    .EQ_RETRY_LIMIT        (EQ_RETRY_LIMIT)
  ) u_step (
    .st               (st),
    .item             (in_item),
    .num_lanes        (num_lanes),
    .pattern3_allowed (pattern3_allowed),
    .st_next          (st_next),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.action;
  assign m_axis_tdata  = {5'b0, out_res.fail_reason, out_res.preemph_max_flag,
                          out_res.swing_max_flag, out_res.drive_preemph,
                          out_res.drive_voltage, out_res.pattern};

endmodule

`default_nettype wire

// ----- hw/rtl/dplt_checker.sv -----
// ----------------------------------------------------------------------------
// dplt_checker
// Port-level checks on the result stream of the training sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dp_link_training_sequencer_top_macros.svh"

module dplt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);
  import dplt_pkg::*;

  `DPLT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `DPLT_ASSERT_IMP(a_reason_only_on_fail, m_axis_tvalid && m_axis_tuser != ACT_FAILED, m_axis_tdata[10:8] == FAIL_NONE)
  `DPLT_ASSERT_IMP(a_pattern_off_at_end, m_axis_tvalid && (m_axis_tuser == ACT_DONE || m_axis_tuser == ACT_FAILED), m_axis_tdata[1:0] == PAT_OFF)
  `DPLT_ASSERT_IMP(a_ignored_is_zero, m_axis_tvalid && m_axis_tuser == ACT_IGNORED, m_axis_tdata == 16'd0)
  `DPLT_ASSERT_IMP(a_swing_flag_match, m_axis_tvalid, m_axis_tdata[6] == (m_axis_tdata[3:2] == LEVEL_MAX))

endmodule

bind dp_link_training_sequencer_top dplt_checker u_dplt_checker (.*);

`default_nettype wire

// ----- dv/dp_link_training_sequencer_top_tb.sv -----
// ----------------------------------------------------------------------------
// dp_link_training_sequencer_top_tb
// Drives start and sink status requests into the link training sequencer,
// predicts each action from its own copy of the training state, and checks
// every result field. Both stream sides idle at random per request, and the
// lane count and pattern registers are rewritten between phases.
// ----------------------------------------------------------------------------
module dp_link_training_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dplt_pkg::*;

  localparam int CR_SAME_VOLTAGE_LIMIT = 5;
  localparam int EQ_RETRY_LIMIT        = 5;
  localparam int QUIET_LIMIT           = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_NUM_LANES;
  logic [2:0]  cfg_data = '0;

  dp_link_training_sequencer_top #(
    .MAX_LANES(LANES),
    .CR_SAME_VOLTAGE_LIMIT(CR_SAME_VOLTAGE_LIMIT),
    .EQ_RETRY_LIMIT(EQ_RETRY_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // training state and registers as the sequencer should hold them
  dplt_phase_t lt_phase      = PH_IDLE;
  logic [2:0]  tries         = '0;
  logic [1:0]  last_swing    = '0;
  logic        last_swing_ok = 1'b0;
  logic [1:0]  swing_lvl     = '0;
  logic [1:0]  emph_lvl      = '0;
  logic        swing_max     = 1'b0;
  logic        emph_max      = 1'b0;
  logic [2:0]  lanes_cfg     = 3'd1;
  logic        pat3          = 1'b0;

  dplt_item_t   pending_reports[$];
  dplt_result_t expected_actions[$];
  dplt_item_t   bus_item;
  int           src_gap = 0;
  int           sink_wait = 0;
  int           queued = 0;
  int           mismatches = 0;
  int           quiet = 0;
  logic         no_idle = 1'b0;

  function automatic int active_lane_num();
    if (lanes_cfg == 3'd0) return 1;
    if (lanes_cfg > LANES) return LANES;
    return lanes_cfg;
  endfunction

  function automatic logic [3:0] active_mask();
    return 4'((1 << active_lane_num()) - 1);
  endfunction

  function automatic logic [1:0] eq_pattern();
    return pat3 ? PAT_3 : PAT_2;
  endfunction

  function automatic dplt_result_t levels_result(logic [2:0] act, logic [1:0] pat,
                                                 logic [2:0] why);
    dplt_result_t r;
    r.action           = act;
    r.pattern          = pat;
    r.drive_voltage    = swing_lvl;
    r.drive_preemph    = emph_lvl;
    r.swing_max_flag   = swing_max;
    r.preemph_max_flag = emph_max;
    r.fail_reason      = why;
    return r;
  endfunction

  function automatic dplt_result_t end_training(logic [2:0] act, logic [2:0] why);
    lt_phase = PH_IDLE;
    return levels_result(act, PAT_OFF, why);
  endfunction

  function automatic void take_request(logic [7:0] rv, logic [7:0] rp);
    logic [1:0] v;
    logic [1:0] p;
    v = '0;
    p = '0;
    for (int k = 0; k < active_lane_num(); k++) begin
      if (rv[2*k +: 2] > v) v = rv[2*k +: 2];
      if (rp[2*k +: 2] > p) p = rp[2*k +: 2];
    end
    swing_lvl = v;
    emph_lvl  = p;
    swing_max = (v == LEVEL_MAX);
    emph_max  = (p == LEVEL_MAX);
  endfunction

  function automatic dplt_result_t train_step(dplt_item_t it);
    dplt_result_t r;
    logic [3:0]   m;
    m = active_mask();
    r = '{action: ACT_IGNORED, pattern: PAT_OFF, fail_reason: FAIL_NONE, default: '0};
    if (!it.mode) begin
      lt_phase      = PH_CR;
      tries         = '0;
      last_swing    = '0;
      last_swing_ok = 1'b0;
      swing_lvl     = '0;
      emph_lvl      = '0;
      swing_max     = 1'b0;
      emph_max      = 1'b0;
      r = levels_result(ACT_SET_PATTERN, PAT_1, FAIL_NONE);
    end else if (lt_phase == PH_CR) begin
      if (!it.status_read_ok) begin
        r = end_training(ACT_FAILED, FAIL_READ);
      end else if ((it.lane_cr_done & m) == m) begin
        lt_phase = PH_EQ;
        tries    = '0;
        r = levels_result(ACT_SET_PATTERN, eq_pattern(), FAIL_NONE);
      end else if (swing_max) begin
        r = end_training(ACT_FAILED, FAIL_MAX_SWING);
      end else begin
        if (last_swing_ok && last_swing == swing_lvl) tries = tries + 3'd1;
        else tries = '0;
        if (tries == CR_SAME_VOLTAGE_LIMIT) begin
          r = end_training(ACT_FAILED, FAIL_CR_RETRY);
        end else begin
          last_swing    = swing_lvl;
          last_swing_ok = 1'b1;
          take_request(it.req_voltage, it.req_preemph);
          r = levels_result(ACT_SET_LEVELS, PAT_1, FAIL_NONE);
        end
      end
    end else if (lt_phase == PH_EQ) begin
      if (!it.status_read_ok) begin
        r = end_training(ACT_FAILED, FAIL_READ);
      end else if ((it.lane_cr_done & m) == m && (it.lane_eq_done & m) == m &&
                   it.lanes_aligned) begin
        r = end_training(ACT_DONE, FAIL_NONE);
      end else if (tries > EQ_RETRY_LIMIT) begin
        r = end_training(ACT_FAILED, FAIL_EQ_RETRY);
      end else begin
        take_request(it.req_voltage, it.req_preemph);
        tries = tries + 3'd1;
        r = levels_result(ACT_SET_LEVELS, eq_pattern(), FAIL_NONE);
      end
    end
    return r;
  endfunction

  function automatic dplt_item_t rand_item();
    logic [31:0] rnd;
    rnd = $urandom;
    return rnd[$bits(dplt_item_t)-1:0];
  endfunction

  function automatic dplt_item_t start_item();
    dplt_item_t it;
    it = rand_item();
    it.mode = 1'b0;
    return it;
  endfunction

  function automatic dplt_item_t report(logic ok, logic [3:0] cr, logic [3:0] eq,
                                        logic aligned, logic [7:0] rv, logic [7:0] rp);
    dplt_item_t it;
    it.mode           = 1'b1;
    it.status_read_ok = ok;
    it.lane_cr_done   = cr;
    it.lane_eq_done   = eq;
    it.lanes_aligned  = aligned;
    it.req_voltage    = rv;
    it.req_preemph    = rp;
    return it;
  endfunction

  function automatic logic [3:0] drop_lane(logic [3:0] bits);
    return bits & ~(4'b0001 << $urandom_range(0, active_lane_num() - 1));
  endfunction

  task automatic queue_item(dplt_item_t it);
    pending_reports.push_back(it);
    queued++;
  endtask

  // one training attempt with random content, or a burst of noise
  task automatic queue_run();
    int         style;
    int         reps;
    logic [1:0] lvl;
    logic [7:0] vmask;
    dplt_item_t it;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      reps = $urandom_range(1, 4);
      repeat (reps) queue_item(rand_item());
      return;
    end
    queue_item(start_item());
    lvl = 2'($urandom_range(0, 2));
    case ($urandom_range(0, 2))
      0: vmask = 8'h55;
      1: vmask = 8'hAA;
      default: vmask = 8'hFF;
    endcase
    reps = (style <= 2) ? $urandom_range(4, 7) : $urandom_range(0, 4);
    repeat (reps) begin
      it = rand_item();
      it.mode           = 1'b1;
      it.status_read_ok = ($urandom_range(0, 24) != 0);
      it.lane_cr_done   = drop_lane(it.lane_cr_done);
      it.req_voltage    = (style <= 2) ? {4{lvl}} : (it.req_voltage & vmask);
      queue_item(it);
    end
    it = rand_item();
    it.mode           = 1'b1;
    it.status_read_ok = 1'b1;
    it.lane_cr_done   = it.lane_cr_done | active_mask();
    queue_item(it);
    reps = (style <= 4) ? $urandom_range(5, 8) : $urandom_range(0, 4);
    repeat (reps) begin
      it = rand_item();
      it.mode           = 1'b1;
      it.status_read_ok = ($urandom_range(0, 24) != 0);
      case ($urandom_range(0, 2))
        0: it.lanes_aligned = 1'b0;
        1: it.lane_eq_done  = drop_lane(it.lane_eq_done);
        default: it.lane_cr_done = drop_lane(it.lane_cr_done);
      endcase
      queue_item(it);
    end
    if ($urandom_range(0, 5) != 0) begin
      it = rand_item();
      it.mode           = 1'b1;
      it.status_read_ok = 1'b1;
      it.lane_cr_done   = it.lane_cr_done | active_mask();
      it.lane_eq_done   = it.lane_eq_done | active_mask();
      it.lanes_aligned  = 1'b1;
      queue_item(it);
    end
    if ($urandom_range(0, 3) == 0) begin
      it = rand_item();
      it.mode = 1'b1;
      queue_item(it);
    end
  endtask

  task automatic drain_and_settle();
    do @(negedge clk);
    while (pending_reports.size() != 0 || s_axis_tvalid || expected_actions.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [2:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_NUM_LANES) lanes_cfg = val;
    else pat3 = val[0];
  endtask

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    logic       took;
    dplt_item_t nxt;
    took = s_axis_tvalid && s_axis_tready;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (took) expected_actions.push_back(train_step(bus_item));
      if (!s_axis_tvalid || took) begin
        if (src_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pending_reports.size() != 0) begin
          nxt = pending_reports.pop_front();
          bus_item      <= nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.mode;
          s_axis_tdata  <= {6'd0, nxt.req_preemph, nxt.req_voltage, nxt.lanes_aligned,
                            nxt.lane_eq_done, nxt.lane_cr_done, nxt.status_read_ok};
          src_gap <= no_idle ? 0 : $urandom_range(0, 8);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    dplt_result_t want;
    int           g;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (expected_actions.size() == 0) begin
        $error("result with no request pending: action %0d", m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_actions.pop_front();
        check_field("action", 8'(want.action), 8'(m_axis_tuser));
        check_field("pattern", 8'(want.pattern), 8'(m_axis_tdata[1:0]));
        check_field("drive_voltage", 8'(want.drive_voltage), 8'(m_axis_tdata[3:2]));
        check_field("drive_preemph", 8'(want.drive_preemph), 8'(m_axis_tdata[5:4]));
        check_field("swing_max_flag", 8'(want.swing_max_flag), 8'(m_axis_tdata[6]));
        check_field("preemph_max_flag", 8'(want.preemph_max_flag), 8'(m_axis_tdata[7]));
        check_field("fail_reason", 8'(want.fail_reason), 8'(m_axis_tdata[10:8]));
      end
      g = no_idle ? 0 : $urandom_range(0, 8);
      m_axis_tready <= (g == 0);
      sink_wait <= g;
    end else if (!m_axis_tready) begin
      if (sink_wait <= 1) m_axis_tready <= 1'b1;
      else sink_wait <= sink_wait - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("dp_link_training_sequencer_top: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  logic [2:0] lane_plan [8] = '{3'd2, 3'd1, 3'd4, 3'd0, 3'd7, 3'd5, 3'd3, 3'd6};

  initial begin
    int target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // report while idle, read failure, max swing, stuck voltage, eq retries
    queue_item(report(1'b1, 4'hF, 4'hF, 1'b1, 8'hFF, 8'hFF));
    queue_item(start_item());
    queue_item(report(1'b0, 4'hF, 4'hF, 1'b1, 8'hFF, 8'hFF));
    queue_item(start_item());
    queue_item(report(1'b1, 4'h0, 4'h0, 1'b0, 8'hFF, 8'hFF));
    queue_item(report(1'b1, 4'hE, 4'h0, 1'b0, 8'h00, 8'h00));
    queue_item(start_item());
    repeat (6) queue_item(report(1'b1, 4'h0, 4'hF, 1'b1, 8'h00, 8'hFC));
    queue_item(start_item());
    queue_item(report(1'b1, 4'h1, 4'h0, 1'b0, 8'h00, 8'h00));
    for (int i = 0; i < 7; i++)
      queue_item(report(1'b1, 4'h1, 4'h1, 1'b0, 8'(i), 8'(i * 37)));
    drain_and_settle();
    write_reg(CFG_NUM_LANES, 3'd4);
    write_reg(CFG_PATTERN3, 3'd1);
    queue_item(start_item());
    queue_item(report(1'b1, 4'hF, 4'h0, 1'b0, 8'h00, 8'h00));
    // flip the pattern register while equalizing
    drain_and_settle();
    write_reg(CFG_PATTERN3, 3'd0);
    queue_item(report(1'b1, 4'h7, 4'hF, 1'b1, 8'hE4, 8'h1B));
    queue_item(start_item());
    queue_item(report(1'b1, 4'hF, 4'hF, 1'b1, 8'h00, 8'h00));
    queue_item(report(1'b1, 4'hF, 4'hF, 1'b1, 8'h00, 8'h00));

    for (int ph = 0; ph < 8; ph++) begin
      drain_and_settle();
      write_reg(CFG_NUM_LANES, lane_plan[ph]);
      write_reg(CFG_PATTERN3, {2'($urandom_range(0, 3)), ph[0]});
      no_idle = (ph == 2 || ph == 5);
      target = queued + 165;
      while (queued < target) queue_run();
    end

    drain_and_settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("dp_link_training_sequencer_top: match");
    end else begin
      $display("dp_link_training_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
